>>> rtl/core/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Shared types and code values for the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Request kinds carried in req_type.
  localparam logic [2:0] REQ_LOAD  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_EVENT = 3'd2;
  localparam logic [2:0] REQ_TICK  = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_WRITE_COUNT    = 2'd1;
  localparam logic [1:0] REG_READ_COUNT     = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_LIMIT  = 2'd3;

  // Controller status codes.
  localparam logic [7:0] SC_START        = 8'h08;
  localparam logic [7:0] SC_REP_START    = 8'h10;
  localparam logic [7:0] SC_SLA_W_ACK    = 8'h18;
  localparam logic [7:0] SC_SLA_W_NACK   = 8'h20;
  localparam logic [7:0] SC_DATA_TX_ACK  = 8'h28;
  localparam logic [7:0] SC_DATA_TX_NACK = 8'h30;
  localparam logic [7:0] SC_ARB_LOST     = 8'h38;
  localparam logic [7:0] SC_SLA_R_ACK    = 8'h40;
  localparam logic [7:0] SC_SLA_R_NACK   = 8'h48;
  localparam logic [7:0] SC_DATA_RX_ACK  = 8'h50;
  localparam logic [7:0] SC_DATA_RX_NACK = 8'h58;

  localparam logic [4:0] POS_MAX = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_BUSY     = 3'd1,
    ST_OK       = 3'd2,
    ST_NODATA   = 3'd3,
    ST_NACKADDR = 3'd4,
    ST_NACKDATA = 3'd5,
    ST_TIMEOUT  = 3'd6
  } txn_status_t;

  // Decision made for one word, completed by the registered store read data in the output stage.
  typedef struct packed {
    logic [7:0]  tx_const;
    logic        use_payload;
    logic        use_received;
    logic        tx_valid;
    logic        set_start;
    logic        set_stop;
    logic        set_ack;
    logic        clear_ack;
    logic        clear_interrupt;
    logic        clear_start;
    logic        finished;
    txn_status_t txn_status;
  } step_t;

  // Store accesses requested by the controller for one word.
  typedef struct packed {
    logic [4:0] pay_pos;
    logic       rx_we;
    logic [4:0] rx_pos;
  } mem_req_t;

endpackage

>>> rtl/core/i2cms_if.sv
// ----------------------------------------------------------------------------
// I2C master sequencer channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cms_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [3:0] index;
  logic [7:0] data_byte;
  logic [7:0] status_code;

  modport source (output valid, req_type, index, data_byte, status_code, input ready);
  modport sink (input valid, req_type, index, data_byte, status_code, output ready);
endinterface

interface i2cms_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       set_start;
  logic       set_stop;
  logic       set_ack;
  logic       clear_ack;
  logic       clear_interrupt;
  logic       clear_start;
  logic [2:0] txn_status;
  logic [7:0] read_byte;
  logic       finished;

  modport source (output valid, tx_byte, tx_valid, set_start, set_stop, set_ack, clear_ack,
                  clear_interrupt, clear_start, txn_status, read_byte, finished,
                  input ready);
  modport sink (input valid, tx_byte, tx_valid, set_start, set_stop, set_ack, clear_ack,
                clear_interrupt, clear_start, txn_status, read_byte, finished,
                output ready);
endinterface

>>> rtl/core/i2cms_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/i2cms_ctrl.sv
// ----------------------------------------------------------------------------
// I2C master sequencer control
// Transaction state, send and receive positions and the timeout counter.
// ----------------------------------------------------------------------------
module i2cms_ctrl import i2cms_pkg::*; #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [2:0]  req_type,
  input  logic [3:0]  index,
  input  logic [7:0]  status_code,
  input  logic [6:0]  device_address,
  input  logic [3:0]  write_count,
  input  logic [3:0]  read_count,
  input  logic [23:0] timeout_limit,
  output step_t       step,
  output mem_req_t    mreq
);

  txn_status_t state, state_next;
  logic [4:0]  send_pos, send_pos_next;
  logic [4:0]  recv_pos, recv_pos_next;
  logic [23:0] wait_cnt, wait_cnt_next;

  logic [4:0] tx_pos;
  logic [4:0] k;
  logic [5:0] wc_plus1;
  logic [5:0] recv_plus1;
  logic       do_tx;
  logic       do_rx;
  logic       ack_check;

  function automatic logic [4:0] sat_inc(input logic [4:0] p);
    return (p < POS_MAX) ? p + 5'd1 : POS_MAX;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      send_pos <= '0;
      recv_pos <= '0;
      wait_cnt <= '0;
    end else if (accept) begin
      state    <= state_next;
      send_pos <= send_pos_next;
      recv_pos <= recv_pos_next;
      wait_cnt <= wait_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    send_pos_next = send_pos;
    recv_pos_next = recv_pos;
    wait_cnt_next = wait_cnt;
    step          = '0;
    mreq          = '0;
    tx_pos        = send_pos;
    do_tx         = 1'b0;
    do_rx         = 1'b0;
    ack_check     = 1'b0;
    k             = '0;
    wc_plus1      = {2'b00, write_count} + 6'd1;
    recv_plus1    = '0;

    case (req_type)
      REQ_START: begin
        if (state != ST_BUSY && 32'(wc_plus1) <= BUFFER_DEPTH) begin
          state_next     = ST_BUSY;
          wait_cnt_next  = '0;
          step.set_start = 1'b1;
        end
      end
      REQ_EVENT: begin
        step.clear_interrupt = 1'b1;
        if (state == ST_BUSY) begin
          wait_cnt_next = '0;
          case (status_code)
            SC_START: begin
              tx_pos           = '0;
              do_tx            = 1'b1;
              step.clear_start = 1'b1;
            end
            SC_REP_START: begin
              recv_pos_next    = '0;
              do_tx            = 1'b1;
              step.clear_start = 1'b1;
            end
            SC_SLA_W_ACK: begin
              if (write_count == '0) begin
                step.set_stop = 1'b1;
                state_next    = ST_NODATA;
              end else begin
                do_tx = 1'b1;
              end
            end
            SC_DATA_TX_ACK: begin
              if ({1'b0, send_pos} < wc_plus1) begin
                do_tx = 1'b1;
              end else if (read_count != '0) begin
                step.set_start = 1'b1;
              end else begin
                step.set_stop = 1'b1;
                state_next    = ST_OK;
              end
            end
            SC_DATA_TX_NACK: begin
              step.set_stop = 1'b1;
              state_next    = ST_NACKDATA;
            end
            SC_SLA_R_ACK: begin
              ack_check = 1'b1;
            end
            SC_DATA_RX_ACK: begin
              do_rx     = 1'b1;
              ack_check = 1'b1;
            end
            SC_DATA_RX_NACK: begin
              do_rx         = 1'b1;
              step.set_stop = 1'b1;
              state_next    = ST_OK;
            end
            SC_SLA_W_NACK, SC_SLA_R_NACK: begin
              step.set_stop = 1'b1;
              state_next    = ST_NACKADDR;
            end
            default: begin
            end
          endcase

          // A received byte goes to the store when its position is in range;
          // the position advances regardless, saturating at 31.
          if (do_rx) begin
            mreq.rx_we    = 32'(recv_pos) < BUFFER_DEPTH;
            mreq.rx_pos   = recv_pos;
            recv_pos_next = sat_inc(recv_pos);
          end
          if (ack_check) begin
            recv_plus1 = {1'b0, recv_pos_next} + 6'd1;
            if (recv_plus1 < {2'b00, read_count}) begin
              step.set_ack = 1'b1;
            end else begin
              step.clear_ack = 1'b1;
            end
          end

          // Byte sequence: write address, payload, then read address.
          if (do_tx) begin
            step.tx_valid = 1'b1;
            send_pos_next = sat_inc(tx_pos);
            if (tx_pos == '0) begin
              step.tx_const = {device_address, 1'b0};
            end else if ({1'b0, tx_pos} <= {2'b00, write_count}) begin
              k = tx_pos - 5'd1;
              if (32'(k) < BUFFER_DEPTH) begin
                step.use_payload = 1'b1;
                mreq.pay_pos     = k;
              end
            end else if ({1'b0, tx_pos} == wc_plus1) begin
              step.tx_const = {device_address, 1'b1};
            end
          end

          if (state_next != ST_BUSY) begin
            step.finished    = 1'b1;
            step.clear_start = 1'b1;
          end
        end
      end
      REQ_TICK: begin
        if (state == ST_BUSY) begin
          if (wait_cnt >= timeout_limit) begin
            state_next       = ST_TIMEOUT;
            step.finished    = 1'b1;
            step.clear_start = 1'b1;
          end else begin
            wait_cnt_next = wait_cnt + 24'd1;
          end
        end
      end
      REQ_READ: begin
        step.use_received = 32'(index) < BUFFER_DEPTH;
      end
      default: begin
      end
    endcase

    step.txn_status = state_next;
  end

endmodule

>>> rtl/core/i2c_master_transaction_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master transaction sequencer
// Turns controller status codes into data bytes and controller commands.
// ----------------------------------------------------------------------------
// The block takes one request word every clock cycle while the result side
// is not stalled and returns exactly one result word per request. The
// decision stage decides the transaction step and reads both the payload
// and received-byte stores; the output stage merges the registered step and
// store data into the output register. The output register and the decision
// stage decouple the two sides, so a stalled result does not stop the next
// request from being taken until both stages hold a word. Configuration is
// written through a simple write port; the user must do so only while the
// block is idle, which it does not enforce; no clearing pass follows reset.
module i2c_master_transaction_sequencer import i2cms_pkg::*; #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  i2cms_cmd_if.sink   cmd,
  i2cms_res_if.source res,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic [6:0]  device_address;
  logic [3:0]  write_count;
  logic [3:0]  read_count;
  logic [23:0] timeout_limit;

  logic     accept;
  step_t    step;
  mem_req_t mreq;

  logic     s1_valid;
  step_t    s1_step;
  logic     s1_move;
  logic     pay_we;
  logic [7:0] pay_rdata;
  logic [7:0] rx_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= '0;
      write_count    <= '0;
      read_count     <= '0;
      timeout_limit  <= 24'd65535;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        REG_WRITE_COUNT:    write_count    <= cfg_data[3:0];
        REG_READ_COUNT:     read_count     <= cfg_data[3:0];
        REG_TIMEOUT_LIMIT:  timeout_limit  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s1_move   = s1_valid && (!res.valid || res.ready);
  assign cmd.ready = !s1_valid || s1_move;
  assign accept    = cmd.valid && cmd.ready;

  i2cms_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .req_type      (cmd.req_type),
    .index         (cmd.index),
    .status_code   (cmd.status_code),
    .device_address(device_address),
    .write_count   (write_count),
    .read_count    (read_count),
    .timeout_limit (timeout_limit),
    .step          (step),
    .mreq          (mreq)
  );

  assign pay_we = accept && cmd.req_type == REQ_LOAD && 32'(cmd.index) < BUFFER_DEPTH;

  // Read data is only refreshed on acceptance, so it holds while stalled.
  i2cms_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_payload_ram (
    .clk  (clk),
    .we   (pay_we),
    .waddr(AW'(cmd.index)),
    .wdata(cmd.data_byte),
    .re   (accept),
    .raddr(AW'(mreq.pay_pos)),
    .rdata(pay_rdata)
  );

  i2cms_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_received_ram (
    .clk  (clk),
    .we   (accept && mreq.rx_we),
    .waddr(AW'(mreq.rx_pos)),
    .wdata(cmd.data_byte),
    .re   (accept),
    .raddr(AW'(cmd.index)),
    .rdata(rx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_move) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res.tx_byte         <= s1_step.use_payload ? pay_rdata : s1_step.tx_const;
      res.tx_valid        <= s1_step.tx_valid;
      res.set_start       <= s1_step.set_start;
      res.set_stop        <= s1_step.set_stop;
      res.set_ack         <= s1_step.set_ack;
      res.clear_ack       <= s1_step.clear_ack;
      res.clear_interrupt <= s1_step.clear_interrupt;
      res.clear_start     <= s1_step.clear_start;
      res.txn_status      <= 3'(s1_step.txn_status);
      res.read_byte       <= s1_step.use_received ? rx_rdata : 8'd0;
      res.finished        <= s1_step.finished;
    end
  end

endmodule
